// ===== rtl/dfa_longest_match_runner_defines.svh =====
// assertion macros for the dfa longest-match runner checker
`ifndef DFA_LONGEST_MATCH_RUNNER_DEFINES_SVH
`define DFA_LONGEST_MATCH_RUNNER_DEFINES_SVH

// same-cycle implication, off during reset
`define DLM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define DLM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// what must hold in the cycle after reset
`define DLM_ASSERT_RST(label, clk, rst, cons, msg) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/dlm_pkg.sv =====
// shared types and constants for the dfa longest-match runner
`timescale 1ns / 1ps

package dlm_pkg;

   localparam int NODE_W      = 6;
   localparam int CHAR_W      = 8;
   localparam int CMD_W       = 2;
   localparam int POS_W       = 16;
   localparam int VERDICT_W   = 2;
   localparam int NODES       = 1 << NODE_W;
   localparam int TBL_AW      = NODE_W + CHAR_W;
   localparam int TBL_DEPTH   = 1 << TBL_AW;
   localparam int QUEUE_AW    = 1;
   localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

   localparam logic [POS_W-1:0] POS_MAX = 16'hFFFF;

   localparam logic [CMD_W-1:0] CMD_TRANS = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FLAGS = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CHAR  = 2'd2;

   localparam logic [VERDICT_W-1:0] VERDICT_REJECT  = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_PARTIAL = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_FULL    = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [NODE_W-1:0] node_index;
      logic [CHAR_W-1:0] char_code;
      logic [NODE_W-1:0] next_node;
      logic              edge_present;
      logic              accept_flag;
      logic              dead_flag;
      logic              is_last;
   } op_type;

   typedef struct packed {
      logic              present;
      logic [NODE_W-1:0] next;
   } edge_type;

   typedef struct packed {
      logic dead;
      logic accept;
   } flags_type;

endpackage

// ===== rtl/dlm_front.sv =====
// front end: takes request beats, drops unused commands, holds one op
`timescale 1ns / 1ps

module dlm_front
   import dlm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [NODE_W-1:0] req_node_index,
   input  logic [CHAR_W-1:0] req_char_code,
   input  logic [NODE_W-1:0] req_next_node,
   input  logic              req_edge_present,
   input  logic              req_accept_flag,
   input  logic              req_dead_flag,
   input  logic              req_is_last,
   output logic              out_valid,
   input  logic              out_ready,
   output op_type            out_op
);

   logic   hold_valid_ff, hold_valid_in;
   op_type hold_op_ff, hold_op_in;
   logic   accept;
   logic   keep;

   assign req_ready = !hold_valid_ff || out_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      unique case (req_cmd)
         CMD_TRANS, CMD_FLAGS, CMD_CHAR: keep = 1'b1;
         default:                        keep = 1'b0;
      endcase
   end

   always_comb begin
      hold_valid_in = hold_valid_ff && !out_ready;
      hold_op_in    = hold_op_ff;
      if (accept) begin
         hold_valid_in           = keep;
         hold_op_in.cmd          = req_cmd;
         hold_op_in.node_index   = req_node_index;
         hold_op_in.char_code    = req_char_code;
         hold_op_in.next_node    = req_next_node;
         hold_op_in.edge_present = req_edge_present;
         hold_op_in.accept_flag  = req_accept_flag;
         hold_op_in.dead_flag    = req_dead_flag;
         hold_op_in.is_last      = req_is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_op_ff <= hold_op_in;
   end

   assign out_valid = hold_valid_ff;
   assign out_op    = hold_op_ff;

endmodule

// ===== rtl/dlm_queue.sv =====
// two-entry op queue between front and back
`timescale 1ns / 1ps

module dlm_queue
   import dlm_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   push_valid,
   output logic   push_ready,
   input  op_type push_op,
   output logic   pop_valid,
   input  logic   pop_ready,
   output op_type pop_op
);

   op_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                push;
   logic                pop;

   assign push_ready = count_ff != (QUEUE_AW + 1)'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_op     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ===== rtl/dlm_back.sv =====
// back end: table writes, character walk in stages s1 and s2, verdict register
`timescale 1ns / 1ps

module dlm_back
   import dlm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [NODE_W-1:0]    csr_start_node,
   input  logic                 op_valid,
   output logic                 op_ready,
   input  op_type               op,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [VERDICT_W-1:0] rsp_verdict,
   output logic [POS_W-1:0]     rsp_match_pos
);

   edge_type  tbl_mem [TBL_DEPTH];
   flags_type flg_mem [NODES];

   edge_type  tbl_rd_ff;
   flags_type flg_rd_ff;
   edge_type  s2_edge_ff;

   logic [NODE_W-1:0]    start_node_ff, start_node_in;
   logic                 fresh_ff, fresh_in;
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_last_ff, s1_last_in;
   logic                 s2_valid_ff, s2_valid_in;
   logic                 s2_last_ff, s2_last_in;
   logic [NODE_W-1:0]    cur_node_ff, cur_node_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic                 match_valid_ff, match_valid_in;
   logic [POS_W-1:0]     match_at_ff, match_at_in;
   logic                 full_ff, full_in;
   logic                 stopped_ff, stopped_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VERDICT_W-1:0] rsp_verdict_ff, rsp_verdict_in;
   logic [POS_W-1:0]     rsp_pos_ff, rsp_pos_in;

   logic              advance;
   logic              pop;
   logic              pop_trans;
   logic              pop_flags;
   logic              pop_char;
   logic              commit;
   logic              hit;
   logic [NODE_W-1:0] rd_node;
   logic [TBL_AW-1:0] tbl_wr_addr;
   logic [TBL_AW-1:0] tbl_rd_addr;

   assign csr_ready     = 1'b1;
   assign start_node_in = csr_valid ? csr_start_node : start_node_ff;

   // whole pipe holds only when a verdict cannot leave
   assign advance   = !(s2_valid_ff && s2_last_ff && rsp_valid_ff && !rsp_ready);
   assign op_ready  = advance;
   assign pop       = op_valid && advance;
   assign pop_trans = pop && (op.cmd == CMD_TRANS);
   assign pop_flags = pop && (op.cmd == CMD_FLAGS);
   assign pop_char  = pop && (op.cmd == CMD_CHAR);
   assign commit    = advance && s2_valid_ff;

   // newest known node of the running string, bypassed from later stages
   always_comb begin
      if (fresh_ff) begin
         rd_node = start_node_ff;
      end else if (s1_valid_ff) begin
         rd_node = tbl_rd_ff.next;
      end else if (s2_valid_ff) begin
         rd_node = s2_edge_ff.next;
      end else begin
         rd_node = cur_node_ff;
      end
   end

   assign tbl_wr_addr = {op.node_index, op.char_code};
   assign tbl_rd_addr = {rd_node, op.char_code};

   always_ff @(posedge clock) begin
      if (pop_trans) begin
         tbl_mem[tbl_wr_addr] <= '{present: op.edge_present, next: op.next_node};
      end
      if (pop_char) begin
         tbl_rd_ff <= tbl_mem[tbl_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (pop_flags) begin
         flg_mem[op.node_index] <= '{dead: op.dead_flag, accept: op.accept_flag};
      end
      if (advance && s1_valid_ff) begin
         flg_rd_ff <= flg_mem[tbl_rd_ff.next];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_edge_ff <= tbl_rd_ff;
      end
   end

   always_comb begin
      fresh_in    = pop_char ? op.is_last : fresh_ff;
      s1_valid_in = advance ? pop_char : s1_valid_ff;
      s1_last_in  = advance ? op.is_last : s1_last_ff;
      s2_valid_in = advance ? s1_valid_ff : s2_valid_ff;
      s2_last_in  = advance ? s1_last_ff : s2_last_ff;
   end

   assign hit = s2_edge_ff.present && flg_rd_ff.accept;

   always_comb begin
      cur_node_in    = cur_node_ff;
      pos_in         = pos_ff;
      match_valid_in = match_valid_ff;
      match_at_in    = match_at_ff;
      full_in        = full_ff;
      stopped_in     = stopped_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_pos_in     = rsp_pos_ff;
      if (commit) begin
         if (!stopped_ff) begin
            full_in = hit;
            if (s2_edge_ff.present) begin
               cur_node_in = s2_edge_ff.next;
            end
            if (hit) begin
               match_valid_in = 1'b1;
               match_at_in    = pos_ff;
            end
            stopped_in = !s2_edge_ff.present || flg_rd_ff.dead;
            if (!stopped_in && (pos_ff != POS_MAX)) begin
               pos_in = pos_ff + 1'b1;
            end
         end
         if (s2_last_ff) begin
            rsp_valid_in = 1'b1;
            if (full_in) begin
               rsp_verdict_in = VERDICT_FULL;
            end else if (match_valid_in) begin
               rsp_verdict_in = VERDICT_PARTIAL;
            end else begin
               rsp_verdict_in = VERDICT_REJECT;
            end
            rsp_pos_in     = match_at_in;
            pos_in         = '0;
            match_valid_in = 1'b0;
            match_at_in    = '0;
            full_in        = 1'b0;
            stopped_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_node_ff  <= '0;
         fresh_ff       <= 1'b1;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         cur_node_ff    <= '0;
         pos_ff         <= '0;
         match_valid_ff <= 1'b0;
         match_at_ff    <= '0;
         full_ff        <= 1'b0;
         stopped_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         start_node_ff  <= start_node_in;
         fresh_ff       <= fresh_in;
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s2_valid_in;
         cur_node_ff    <= cur_node_in;
         pos_ff         <= pos_in;
         match_valid_ff <= match_valid_in;
         match_at_ff    <= match_at_in;
         full_ff        <= full_in;
         stopped_ff     <= stopped_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff     <= s1_last_in;
      s2_last_ff     <= s2_last_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_pos_ff     <= rsp_pos_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_verdict   = rsp_verdict_ff;
   assign rsp_match_pos = rsp_pos_ff;

endmodule

// ===== rtl/dfa_longest_match_runner.sv =====
// top level of the dfa longest-match runner
`timescale 1ns / 1ps

// Takes one request beat per clock when nothing stalls: table writes and characters alike.
// A character's verdict passes through the front register, the two-entry queue, two chained
// registered memory reads (transition table, then the flags of the node entered) and the
// verdict register; the next character reads the table with the node forwarded from the
// stage ahead, so the walk keeps one character per cycle unless stalled. The transition
// and flag memories come up unwritten and have no clearing pass: load every entry a string
// can reach before feeding it. start_node is taken up by the first character of a string.

module dfa_longest_match_runner
   import dlm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [CMD_W-1:0]     req_cmd,
   input  logic [NODE_W-1:0]    req_node_index,
   input  logic [CHAR_W-1:0]    req_char_code,
   input  logic [NODE_W-1:0]    req_next_node,
   input  logic                 req_edge_present,
   input  logic                 req_accept_flag,
   input  logic                 req_dead_flag,
   input  logic                 req_is_last,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [VERDICT_W-1:0] rsp_verdict,
   output logic [POS_W-1:0]     rsp_match_pos,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [NODE_W-1:0]    csr_start_node
);

   logic   front_valid;
   logic   front_ready;
   op_type front_op;
   logic   head_valid;
   logic   head_ready;
   op_type head_op;

   dlm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_node_index   (req_node_index),
      .req_char_code    (req_char_code),
      .req_next_node    (req_next_node),
      .req_edge_present (req_edge_present),
      .req_accept_flag  (req_accept_flag),
      .req_dead_flag    (req_dead_flag),
      .req_is_last      (req_is_last),
      .out_valid        (front_valid),
      .out_ready        (front_ready),
      .out_op           (front_op)
   );

   dlm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_op    (front_op),
      .pop_valid  (head_valid),
      .pop_ready  (head_ready),
      .pop_op     (head_op)
   );

   dlm_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_start_node (csr_start_node),
      .op_valid       (head_valid),
      .op_ready       (head_ready),
      .op             (head_op),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_verdict    (rsp_verdict),
      .rsp_match_pos  (rsp_match_pos)
   );

endmodule

// ===== rtl/dlm_checker.sv =====
// port-level checks for the dfa longest-match runner, bound to the top level
`timescale 1ns / 1ps
`include "dfa_longest_match_runner_defines.svh"

module dlm_checker
   import dlm_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [VERDICT_W-1:0] rsp_verdict,
   input logic [POS_W-1:0]     rsp_match_pos
);

   `DLM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_verdict) && $stable(rsp_match_pos), "stalled result beat changed")
   `DLM_ASSERT_IMP(a_reject_pos, clock, reset, rsp_valid && (rsp_verdict == VERDICT_REJECT), rsp_match_pos == '0, "reject beat with nonzero position")
   `DLM_ASSERT_RST(a_reset_quiet, clock, reset, !rsp_valid && req_ready, "block not idle after reset")

endmodule

bind dfa_longest_match_runner dlm_checker u_dlm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_verdict   (rsp_verdict),
   .rsp_match_pos (rsp_match_pos)
);
